[hw/rtl/gke_pkg.sv]
// Shared types and constants for the grid element engine.
// Used by every module of the block; no dependencies of its own.
package gke_pkg;

    // Position counter width; reported coordinates are the low 16 bits
    localparam int COORD_BITS = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MODE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_DIMENSIONS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_X          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_Y          = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_Z          = 3'd4;

    // Kernel modes
    localparam logic [2:0] MODE_COPY   = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_MUL    = 3'd2;
    localparam logic [2:0] MODE_RED    = 3'd3;
    localparam logic [2:0] MODE_ABS    = 3'd4;
    localparam logic [2:0] MODE_MINMAX = 3'd5;

    // Pixel constants
    localparam logic [7:0] RED_THRESHOLD = 8'd100;
    localparam logic [7:0] PIXEL_MAX     = 8'hFF;

    // Queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // Input word
    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } gke_in_t;

    // Result word
    typedef struct packed {
        logic [31:0] element_value;
        logic        grid_done;
        logic [31:0] red_total;
        logic [7:0]  min_value;
        logic [7:0]  max_value;
        logic [15:0] min_x;
        logic [15:0] min_y;
        logic [15:0] max_x;
        logic [15:0] max_y;
    } gke_out_t;

    // Classified element handed from front to back
    typedef struct packed {
        logic [2:0]  mode;
        logic        last;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } gke_entry_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } gke_q_status_t;

endpackage

[hw/rtl/gke_front.sv]
// Front end: configuration registers, grid position counters, element classification.
// Depends on gke_pkg.
module gke_front
    import gke_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  gke_in_t                   in_data,
    input  gke_q_status_t             q_status,
    output logic                      push,
    output gke_entry_t                push_entry,
    output logic                      restart
);

    logic [2:0]            mode_reg;
    logic [1:0]            dims_reg;
    logic [15:0]           size_x_reg;
    logic [15:0]           size_y_reg;
    logic [15:0]           size_z_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_z_reg;

    logic [15:0] ext_x;
    logic [15:0] ext_y;
    logic [15:0] ext_z;
    logic [31:0] pos_x_wide;
    logic [31:0] pos_y_wide;
    logic [31:0] pos_z_wide;
    logic        end_x;
    logic        end_y;
    logic        end_z;
    logic        last;

    // Any write to a known register restarts the grid
    assign restart = cfg_write && (cfg_index <= REG_SIZE_Z);

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_COPY;
            dims_reg   <= 2'd1;
            size_x_reg <= 16'd1;
            size_y_reg <= 16'd1;
            size_z_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KERNEL_MODE:     mode_reg   <= cfg_data[2:0];
                REG_GRID_DIMENSIONS: dims_reg   <= cfg_data[1:0];
                REG_SIZE_X:          size_x_reg <= cfg_data;
                REG_SIZE_Y:          size_y_reg <= cfg_data;
                REG_SIZE_Z:          size_z_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Effective extents: unused axis or zero size acts as one
    assign ext_x = (size_x_reg == 16'd0) ? 16'd1 : size_x_reg;
    assign ext_y = (dims_reg >= 2'd2 && size_y_reg != 16'd0) ? size_y_reg : 16'd1;
    assign ext_z = (dims_reg == 2'd3 && size_z_reg != 16'd0) ? size_z_reg : 16'd1;

    assign pos_x_wide = 32'(pos_x_reg);
    assign pos_y_wide = 32'(pos_y_reg);
    assign pos_z_wide = 32'(pos_z_reg);

    // A coordinate at or past its last index ends that axis
    assign end_x = pos_x_wide >= 32'(ext_x - 16'd1);
    assign end_y = pos_y_wide >= 32'(ext_y - 16'd1);
    assign end_z = pos_z_wide >= 32'(ext_z - 16'd1);
    assign last  = end_x && end_y && end_z;

    // Accept while the queue has room
    assign push = in_valid && !q_status.full;

    assign push_entry.mode      = mode_reg;
    assign push_entry.last      = last;
    assign push_entry.pos_x     = pos_x_wide[15:0];
    assign push_entry.pos_y     = pos_y_wide[15:0];
    assign push_entry.operand_a = in_data.operand_a;
    assign push_entry.operand_b = in_data.operand_b;

    // Advance the grid position on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (restart)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (push)
        begin
            priority if (last)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end
            else if (!end_x)
            begin
                pos_x_reg <= pos_x_reg + 1'b1;
            end
            else if (!end_y)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= pos_y_reg + 1'b1;
            end
            else
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= pos_z_reg + 1'b1;
            end
        end
    end

endmodule

[hw/rtl/gke_queue.sv]
// Short FIFO of classified elements between front and back.
// Depends on gke_pkg.
module gke_queue
    import gke_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gke_entry_t    push_entry,
    input  logic          pop,
    output gke_entry_t    head,
    output gke_q_status_t status
);

    gke_entry_t            store [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS:0]   count_reg;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign head         = store[rd_ptr_reg];

    // Write storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/gke_back.sv]
// Back end: per-element arithmetic, running reductions and the output register.
// Depends on gke_pkg.
module gke_back
    import gke_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  gke_entry_t    head,
    input  gke_q_status_t q_status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output gke_out_t      out_data
);

    logic [31:0] red_reg;
    logic [7:0]  min_reg;
    logic [7:0]  max_reg;
    logic [15:0] min_x_reg;
    logic [15:0] min_y_reg;
    logic [15:0] max_x_reg;
    logic [15:0] max_y_reg;
    logic        out_valid_reg;
    gke_out_t    out_data_reg;

    logic [7:0]  pixel;
    logic [31:0] red_next;
    logic        min_hit;
    logic        max_hit;
    logic [7:0]  min_next;
    logic [7:0]  max_next;
    logic [15:0] min_x_next;
    logic [15:0] min_y_next;
    logic [15:0] max_x_next;
    logic [15:0] max_y_next;
    logic        emit;
    gke_out_t    result;

    // Take the next element when the output slot is free or draining
    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    // Reduction updates
    assign pixel      = head.operand_a[7:0];
    assign red_next   = red_reg + 32'(pixel > RED_THRESHOLD);
    assign min_hit    = pixel < min_reg;
    assign max_hit    = pixel > max_reg;
    assign min_next   = min_hit ? pixel : min_reg;
    assign max_next   = max_hit ? pixel : max_reg;
    assign min_x_next = min_hit ? head.pos_x : min_x_reg;
    assign min_y_next = min_hit ? head.pos_y : min_y_reg;
    assign max_x_next = max_hit ? head.pos_x : max_x_reg;
    assign max_y_next = max_hit ? head.pos_y : max_y_reg;

    // Build the result word
    always_comb
    begin
        result           = '0;
        result.grid_done = head.last;
        emit             = 1'b0;
        unique case (head.mode)
            MODE_COPY:
            begin
                result.element_value = head.operand_a;
                emit                 = 1'b1;
            end
            MODE_ADD:
            begin
                result.element_value = head.operand_a + head.operand_b;
                emit                 = 1'b1;
            end
            MODE_MUL:
            begin
                result.element_value = head.operand_a * head.operand_b;
                emit                 = 1'b1;
            end
            MODE_RED:
            begin
                result.red_total = red_next;
                emit             = head.last;
            end
            MODE_ABS:
            begin
                result.element_value = {1'b0, head.operand_a[30:0]};
                emit                 = 1'b1;
            end
            MODE_MINMAX:
            begin
                result.min_value = min_next;
                result.max_value = max_next;
                result.min_x     = min_x_next;
                result.min_y     = min_y_next;
                result.max_x     = max_x_next;
                result.max_y     = max_y_next;
                emit             = head.last;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Hold running reductions; restart on grid end or configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= '0;
            min_reg   <= PIXEL_MAX;
            max_reg   <= '0;
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (restart || (pop && head.last))
        begin
            red_reg   <= '0;
            min_reg   <= PIXEL_MAX;
            max_reg   <= '0;
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (pop)
        begin
            if (head.mode == MODE_RED)
            begin
                red_reg <= red_next;
            end
            if (head.mode == MODE_MINMAX)
            begin
                min_reg   <= min_next;
                max_reg   <= max_next;
                min_x_reg <= min_x_next;
                min_y_reg <= min_y_next;
                max_x_reg <= max_x_next;
                max_y_reg <= max_y_next;
            end
        end
    end

    // Output register: load on pop, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hw/rtl/builtin_kernel_grid_engine_top.sv]
// An accepted word is written into the queue, then popped into the output register when the output can take it.
// Throughput: one word per cycle while the output is not stalled, set by the back end and output register.
// A four-entry queue parts front and back; a stalled output fills it, then stalls input.
// Reset (rst_n, asynchronous, active low): mode copy, one dimension, sizes one,
// position and reductions cleared, queue and output empty.
module builtin_kernel_grid_engine_top
    import gke_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gke_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gke_out_t                  out_data
);

    logic          push;
    gke_entry_t    push_entry;
    logic          pop;
    gke_entry_t    head;
    gke_q_status_t q_status;
    logic          restart;

    // Stall input while the queue is full
    assign in_stall = q_status.full;

    gke_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry),
        .restart    (restart)
    );

    gke_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    gke_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
